// ----- hw/rtl/bfiq_pkg.sv -----
// Shared constants, command codes, register indexes and config struct for the
// double-hashing Bloom filter block. No dependencies.
`timescale 1ns / 1ps

package bfiq_pkg;

	// Field widths
	localparam int HASH_W  = 64;
	localparam int CMD_W   = 2;
	localparam int TOTAL_W = 32;
	localparam int USED_W  = 17;
	localparam int HCNT_W  = 5;

	// APB port geometry: two registers at byte addresses 0 and 4
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;
	localparam int REG_IDX_LSB = 2;

	// Bit store rows
	localparam int ROW_W   = 64;
	localparam int ROW_LSB = 6;

	// Defaults for top-level parameters
	localparam int DEF_STORE_BITS = 65536;
	localparam int DEF_MAX_PROBES = 16;

	// Command codes; code 3 is ignored
	typedef logic [CMD_W-1:0] bfiq_cmd_t;
	localparam bfiq_cmd_t CMD_ADD   = 2'd0;
	localparam bfiq_cmd_t CMD_QUERY = 2'd1;
	localparam bfiq_cmd_t CMD_CLEAR = 2'd2;

	// Register indexes
	typedef logic [0:0] bfiq_reg_idx_t;
	localparam bfiq_reg_idx_t REG_USED_BITS  = 1'b0;
	localparam bfiq_reg_idx_t REG_HASH_COUNT = 1'b1;

	// Register reset values
	localparam logic [USED_W-1:0] USED_BITS_RST  = 17'd65536;
	localparam logic [HCNT_W-1:0] HASH_COUNT_RST = 5'd4;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		logic [USED_W-1:0] used_bits;
		logic [HCNT_W-1:0] hash_count;
	} bfiq_cfg_t;

endpackage

// ----- hw/rtl/bfiq_if.sv -----
// Valid/ready channel interfaces for command items and result items.
// Depends on bfiq_pkg.
`timescale 1ns / 1ps

interface bfiq_cmd_if import bfiq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [HASH_W-1:0] hash_a;
	logic [HASH_W-1:0] hash_b;

	modport source (output valid, command, hash_a, hash_b, input ready);
	modport sink (input valid, command, hash_a, hash_b, output ready);
endinterface

interface bfiq_rsp_if import bfiq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               present;
	logic [TOTAL_W-1:0] inserted_total;

	modport source (output valid, present, inserted_total, input ready);
	modport sink (input valid, present, inserted_total, output ready);
endinterface

// ----- hw/rtl/bfiq_cfg_regs.sv -----
// APB register file: used_bits and hash_count.
// Depends on bfiq_pkg.
`timescale 1ns / 1ps

module bfiq_cfg_regs import bfiq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output bfiq_cfg_t         cfg
);

	logic [USED_W-1:0] used_bits_q;
	logic [HCNT_W-1:0] hash_count_q;
	bfiq_reg_idx_t     reg_idx;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[REG_IDX_LSB];
	assign wr_en   = psel & penable & pwrite & pready;

	// register writes, data masked to register width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_bits_q  <= USED_BITS_RST;
			hash_count_q <= HASH_COUNT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_USED_BITS:  used_bits_q  <= pwdata[USED_W-1:0];
				REG_HASH_COUNT: hash_count_q <= pwdata[HCNT_W-1:0];
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_USED_BITS:  prdata = APB_DW'(used_bits_q);
			REG_HASH_COUNT: prdata = APB_DW'(hash_count_q);
		endcase
	end

	assign cfg.used_bits  = used_bits_q;
	assign cfg.hash_count = hash_count_q;

endmodule

// ----- hw/rtl/bfiq_mod_unit.sv -----
// Iterative remainder unit: hash_a mod m, hash_b mod m and 2^64 mod m,
// four dividend bits per cycle in three parallel lanes. Depends on bfiq_pkg.
`timescale 1ns / 1ps

module bfiq_mod_unit import bfiq_pkg::*; #(
	parameter int MW = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] a,
	input  logic [HASH_W-1:0] b,
	input  logic [MW-1:0]     m,
	output logic              done,
	output logic [MW-1:0]     a_mod,
	output logic [MW-1:0]     b_mod,
	output logic [MW-1:0]     w
);

	localparam int DPC   = 4;
	localparam int STEPS = HASH_W / DPC;
	localparam int SCW   = $clog2(STEPS);

	logic              busy_q;
	logic              done_q;
	logic [SCW-1:0]    step_q;
	logic [HASH_W-1:0] sa_q;
	logic [HASH_W-1:0] sb_q;
	logic [MW-1:0]     ra_q, rb_q, ro_q;
	logic [MW-1:0]     ra_n, rb_n, ro_n;
	logic [MW:0]       ro_inc;

	// one restoring step: shift in a bit, subtract modulus if it fits
	function automatic logic [MW-1:0] rem_step(input logic [MW-1:0] r,
		input logic bit_in, input logic [MW-1:0] md);
		logic [MW:0] t;
		t = {r, bit_in};
		if (t >= {1'b0, md})
			t = t - {1'b0, md};
		return t[MW-1:0];
	endfunction

	// four steps per cycle; the third lane reduces 2^64-1
	always_comb begin
		ra_n = ra_q;
		rb_n = rb_q;
		ro_n = ro_q;
		for (int j = 0; j < DPC; j++) begin
			ra_n = rem_step(ra_n, sa_q[HASH_W-1-j], m);
			rb_n = rem_step(rb_n, sb_q[HASH_W-1-j], m);
			ro_n = rem_step(ro_n, 1'b1, m);
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SCW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifters and partial remainders
	always_ff @(posedge clk) begin
		if (start) begin
			sa_q <= a;
			sb_q <= b;
			ra_q <= '0;
			rb_q <= '0;
			ro_q <= '0;
		end else if (busy_q) begin
			sa_q <= sa_q << DPC;
			sb_q <= sb_q << DPC;
			ra_q <= ra_n;
			rb_q <= rb_n;
			ro_q <= ro_n;
		end
	end

	// 2^64 mod m = ((2^64-1) mod m + 1) mod m
	assign ro_inc = {1'b0, ro_q} + 1'b1;
	assign w      = (ro_inc == {1'b0, m}) ? '0 : ro_inc[MW-1:0];
	assign a_mod  = ra_q;
	assign b_mod  = rb_q;
	assign done   = done_q;

endmodule

// ----- hw/rtl/bfiq_bit_store.sv -----
// Filter bit store: synchronous RAM of 64-bit rows, one write and one
// registered read port. Depends on bfiq_pkg.
`timescale 1ns / 1ps

module bfiq_bit_store import bfiq_pkg::*; #(
	parameter int ROWS = 1024,
	localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [RAW-1:0]   waddr,
	input  logic [ROW_W-1:0] wdata,
	input  logic             re,
	input  logic [RAW-1:0]   raddr,
	output logic [ROW_W-1:0] rdata
);

	logic [ROW_W-1:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/bloom_filter_insert_query_top.sv -----
// Bloom filter top: add/query/clear items, probe sequencer over one bit RAM.
// Add/query: the remainder unit runs, then one RAM read per probe for k probes, k the effective
// hash_count, then one drain and one output load; the load waits until the output register is free.
// Clear: one row zeroed per cycle, then a result; code 3: a result with no other effect.
// Sequential: the next item is taken in the cycle after the result loads.
// After reset every RAM row is swept to zero; no item is taken then.
`timescale 1ns / 1ps

module bloom_filter_insert_query_top import bfiq_pkg::*; #(
	parameter int STORE_BITS = DEF_STORE_BITS,
	parameter int MAX_PROBES = DEF_MAX_PROBES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	bfiq_cmd_if.sink          cmd,
	bfiq_rsp_if.source        rsp
);

	localparam int MW   = $clog2(STORE_BITS + 1);
	localparam int ROWS = (STORE_BITS + ROW_W - 1) / ROW_W;
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PW   = $clog2(MAX_PROBES + 1);

	typedef enum logic [5:0] {
		ST_SWEEP = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_PREP  = 6'b000100,
		ST_PROBE = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_DONE  = 6'b100000
	} bfiq_state_t;

	bfiq_cfg_t          cfg;
	bfiq_state_t        state_q, state_n;

	logic [MW-1:0]      m_eff;
	logic [PW-1:0]      k_eff;

	logic               in_acc, mod_start, mod_done;
	logic [MW-1:0]      a_mod, b_mod, w_mod;

	bfiq_cmd_t          cmd_q;
	logic [HASH_W-1:0]  a_q, b_q;
	logic [MW-1:0]      r_q, bm_q, w_q, r_next;
	logic [PW-1:0]      pcnt_q;
	logic [RAW-1:0]     sweep_row_q;
	logic               sweep_rsp_q, sweep_last;

	logic [HASH_W:0]    h_sum;
	logic [MW-1:0]      sub_val;
	logic [MW+1:0]      d0, dp, dm;

	logic               probe_go;
	logic [RAW-1:0]     rd_row;
	logic [ROW_W-1:0]   rd_data;

	logic               vld_s1;
	logic [RAW-1:0]     row_s1;
	logic [ROW_LSB-1:0] bit_s1;
	logic [ROW_W-1:0]   fwd_data;
	logic               s1_we;

	logic               wr_vld_q;
	logic [RAW-1:0]     wr_row_q;
	logic [ROW_W-1:0]   wr_data_q;

	logic               mem_we;
	logic [RAW-1:0]     mem_waddr;
	logic [ROW_W-1:0]   mem_wdata;

	logic               all_q;
	logic [TOTAL_W-1:0] ins_cnt_q, total_next;
	logic               out_vld_q, out_present_q, out_free, out_load;
	logic [TOTAL_W-1:0] out_total_q;

	// config registers
	bfiq_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// effective modulus: zero means 1, clamp to store size
	always_comb begin
		if (cfg.used_bits == '0)
			m_eff = MW'(1);
		else if (32'(cfg.used_bits) > 32'(STORE_BITS))
			m_eff = MW'(STORE_BITS);
		else
			m_eff = MW'(cfg.used_bits);
	end

	// effective probe count: zero means 1, clamp to MAX_PROBES
	always_comb begin
		if (cfg.hash_count == '0)
			k_eff = PW'(1);
		else if (32'(cfg.hash_count) > 32'(MAX_PROBES))
			k_eff = PW'(MAX_PROBES);
		else
			k_eff = PW'(cfg.hash_count);
	end

	// handshakes
	assign cmd.ready  = (state_q == ST_IDLE);
	assign in_acc     = cmd.valid & cmd.ready;
	assign mod_start  = in_acc & ((cmd.command == CMD_ADD) || (cmd.command == CMD_QUERY));
	assign out_free   = !out_vld_q | rsp.ready;
	assign out_load   = (state_q == ST_DONE) & out_free;
	assign sweep_last = (sweep_row_q == RAW'(ROWS - 1));
	assign probe_go   = (state_q == ST_PROBE);

	// remainders of the probe base, the step and 2^64
	bfiq_mod_unit #(.MW(MW)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.a      (cmd.hash_a),
		.b      (cmd.hash_b),
		.m      (m_eff),
		.done   (mod_done),
		.a_mod  (a_mod),
		.b_mod  (b_mod),
		.w      (w_mod)
	);

	// next probe index: r + (b mod m), minus 2^64 mod m when the 64-bit sum wraps
	assign h_sum   = {1'b0, a_q} + {1'b0, b_q};
	assign sub_val = h_sum[HASH_W] ? w_q : '0;
	assign d0      = {2'b00, r_q} + {2'b00, bm_q} - {2'b00, sub_val};
	assign dp      = d0 + {2'b00, m_eff};
	assign dm      = d0 - {2'b00, m_eff};

	always_comb begin
		if (d0[MW+1])
			r_next = dp[MW-1:0];
		else if (!dm[MW+1])
			r_next = dm[MW-1:0];
		else
			r_next = d0[MW-1:0];
	end

	assign rd_row = RAW'(r_q >> ROW_LSB);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (sweep_last)
					state_n = sweep_rsp_q ? ST_DONE : ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) begin
					unique case (cmd.command)
						CMD_ADD, CMD_QUERY: state_n = ST_PREP;
						CMD_CLEAR:          state_n = ST_SWEEP;
						default:            state_n = ST_DONE;
					endcase
				end
			end
			ST_PREP: begin
				if (mod_done)
					state_n = ST_PROBE;
			end
			ST_PROBE: begin
				if (pcnt_q == k_eff - PW'(1))
					state_n = ST_DRAIN;
			end
			ST_DRAIN: state_n = ST_DONE;
			ST_DONE: begin
				if (out_free)
					state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_row_q <= '0;
			sweep_rsp_q <= 1'b0;
			pcnt_q      <= '0;
			vld_s1      <= 1'b0;
			wr_vld_q    <= 1'b0;
			ins_cnt_q   <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q  <= state_n;
			vld_s1   <= probe_go;
			wr_vld_q <= s1_we;

			if (state_q == ST_SWEEP)
				sweep_row_q <= sweep_row_q + 1'b1;

			if (in_acc && cmd.command == CMD_CLEAR) begin
				sweep_row_q <= '0;
				sweep_rsp_q <= 1'b1;
				ins_cnt_q   <= '0;
			end

			if (state_q == ST_PREP)
				pcnt_q <= '0;
			else if (probe_go)
				pcnt_q <= pcnt_q + 1'b1;

			if (out_load) begin
				ins_cnt_q <= total_next;
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// item payload and probe sequencer
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= cmd.command;
			a_q   <= cmd.hash_a;
			b_q   <= cmd.hash_b;
		end else if (probe_go) begin
			a_q <= h_sum[HASH_W-1:0];
		end

		if (state_q == ST_PREP && mod_done) begin
			r_q  <= a_mod;
			bm_q <= b_mod;
			w_q  <= w_mod;
		end else if (probe_go) begin
			r_q <= r_next;
		end

		// query verdict: AND of every probed bit as it leaves the read stage
		if (state_q == ST_PREP && mod_done)
			all_q <= 1'b1;
		else if (vld_s1 && cmd_q == CMD_QUERY)
			all_q <= all_q & fwd_data[bit_s1];

		row_s1    <= rd_row;
		bit_s1    <= r_q[ROW_LSB-1:0];
		wr_row_q  <= row_s1;
		wr_data_q <= mem_wdata;

		if (out_load) begin
			out_present_q <= (cmd_q == CMD_QUERY) & all_q;
			out_total_q   <= total_next;
		end
	end

	// read-modify-write stage, forwarding the row written in the previous cycle
	assign fwd_data = (wr_vld_q && wr_row_q == row_s1) ? wr_data_q : rd_data;
	assign s1_we    = vld_s1 & (cmd_q == CMD_ADD);

	// RAM write: clear sweep or probe bit set
	assign mem_we    = (state_q == ST_SWEEP) | s1_we;
	assign mem_waddr = (state_q == ST_SWEEP) ? sweep_row_q : row_s1;
	assign mem_wdata = (state_q == ST_SWEEP) ? '0 : (fwd_data | (ROW_W'(1) << bit_s1));

	bfiq_bit_store #(.ROWS(ROWS)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (probe_go),
		.raddr (rd_row),
		.rdata (rd_data)
	);

	// saturating insert count
	assign total_next = (cmd_q == CMD_ADD && ins_cnt_q != TOTAL_MAX) ?
		ins_cnt_q + 1'b1 : ins_cnt_q;

	assign rsp.valid          = out_vld_q;
	assign rsp.present        = out_present_q;
	assign rsp.inserted_total = out_total_q;

	// probe index always reduced below the modulus
	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (r_q < m_eff))
		else $error("probe index not below modulus");

	// read data stage only live across the probe window
	a_s1_window: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_PROBE || state_q == ST_DRAIN))
		else $error("probe data stage active outside probing");

	// remainder unit finishes only while the sequencer waits for it
	a_mod_done_in_prep: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_PREP))
		else $error("remainder result outside prep");

	// only an add moves the insert count at result time
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && cmd_q != CMD_ADD) |=> (ins_cnt_q == $past(ins_cnt_q)))
		else $error("insert count changed by non-add item");

endmodule
